@@ src/mkd_pkg.sv @@
// shared types, constants and the pattern lookup for the morse key decoder
// no dependencies; used by every module in src

package mkd_pkg;

  // data widths fixed by the item and register formats
  localparam int unsigned LED_W      = 8;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned SYM_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TDATA_W    = 8;

  // longest pattern in the letter and digit table
  localparam int unsigned MORSE_MAX_LEN   = 5;
  localparam int unsigned MAX_SYMBOLS_DEF = 5;
  localparam int unsigned LEN_W           = 3;

  // reset values of the configuration registers
  localparam logic [TICK_W-1:0] DASH_HOLD_RST  = 8'd4;
  localparam logic [TICK_W-1:0] GAP_LIMIT_RST  = 8'd20;
  localparam logic [TICK_W-1:0] DISP_START_RST = 8'd10;

  // led codes
  localparam logic [LED_W-1:0] LED_OFF     = 8'h00;
  localparam logic [LED_W-1:0] LED_DOT     = 8'h01;
  localparam logic [LED_W-1:0] LED_DASH    = 8'h02;
  localparam logic [LED_W-1:0] LED_UNKNOWN = 8'hFF;

  // symbol codes
  localparam logic [SYM_W-1:0] SYM_NONE = 2'd0;
  localparam logic [SYM_W-1:0] SYM_DOT  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_DASH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_START = 2'd2;

  // key timing phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_DOT     = 7'b0000010,
    PH_DASH    = 7'b0000100,
    PH_RECORD  = 7'b0001000,
    PH_WAIT    = 7'b0010000,
    PH_DISPLAY = 7'b0100000,
    PH_HOLD    = 7'b1000000
  } phase_t;

  // configuration register contents
  typedef struct packed {
    logic [TICK_W-1:0] dash_hold_ticks;
    logic [TICK_W-1:0] gap_limit_ticks;
    logic [TICK_W-1:0] display_start_count;
  } cfg_t;

  typedef logic [MORSE_MAX_LEN-1:0][SYM_W-1:0] sym_vec_t;

  // pattern lookup: first symbol ends up in the highest used bit, dash = 1
  function automatic logic [LED_W-1:0] mkd_decode(input logic [LEN_W-1:0] len,
                                                  input sym_vec_t syms);
    logic [MORSE_MAX_LEN-1:0] pat;
    logic                     bad;
    logic [LED_W-1:0]         chr;
    pat = '0;
    bad = 1'b0;
    for (int k = 0; k < MORSE_MAX_LEN; k++) begin
      if (LEN_W'(k) < len) begin
        pat = {pat[MORSE_MAX_LEN-2:0], syms[k] == SYM_DASH};
        if (syms[k] != SYM_DOT && syms[k] != SYM_DASH) bad = 1'b1;
      end
    end
    unique case ({len, pat})
      {3'd2, 5'b00001}: chr = 8'h41; // A
      {3'd4, 5'b01000}: chr = 8'h42; // B
      {3'd4, 5'b01010}: chr = 8'h43; // C
      {3'd3, 5'b00100}: chr = 8'h44; // D
      {3'd1, 5'b00000}: chr = 8'h45; // E
      {3'd4, 5'b00010}: chr = 8'h46; // F
      {3'd3, 5'b00110}: chr = 8'h47; // G
      {3'd4, 5'b00000}: chr = 8'h48; // H
      {3'd2, 5'b00000}: chr = 8'h49; // I
      {3'd4, 5'b00111}: chr = 8'h4A; // J
      {3'd3, 5'b00101}: chr = 8'h4B; // K
      {3'd4, 5'b00100}: chr = 8'h4C; // L
      {3'd2, 5'b00011}: chr = 8'h4D; // M
      {3'd2, 5'b00010}: chr = 8'h4E; // N
      {3'd3, 5'b00111}: chr = 8'h4F; // O
      {3'd4, 5'b00110}: chr = 8'h50; // P
      {3'd4, 5'b01101}: chr = 8'h51; // Q
      {3'd3, 5'b00010}: chr = 8'h52; // R
      {3'd3, 5'b00000}: chr = 8'h53; // S
      {3'd1, 5'b00001}: chr = 8'h54; // T
      {3'd3, 5'b00001}: chr = 8'h55; // U
      {3'd4, 5'b00001}: chr = 8'h56; // V
      {3'd3, 5'b00011}: chr = 8'h57; // W
      {3'd4, 5'b01001}: chr = 8'h58; // X
      {3'd4, 5'b01011}: chr = 8'h59; // Y
      {3'd4, 5'b01100}: chr = 8'h5A; // Z
      {3'd5, 5'b01111}: chr = 8'h31; // 1
      {3'd5, 5'b00111}: chr = 8'h32; // 2
      {3'd5, 5'b00011}: chr = 8'h33; // 3
      {3'd5, 5'b00001}: chr = 8'h34; // 4
      {3'd5, 5'b00000}: chr = 8'h35; // 5
      {3'd5, 5'b10000}: chr = 8'h36; // 6
      {3'd5, 5'b11000}: chr = 8'h37; // 7
      {3'd5, 5'b11100}: chr = 8'h38; // 8
      {3'd5, 5'b11110}: chr = 8'h39; // 9
      {3'd5, 5'b11111}: chr = 8'h30; // 0
      default:          chr = LED_UNKNOWN;
    endcase
    if (bad || len == '0 || len > LEN_W'(MORSE_MAX_LEN)) chr = LED_UNKNOWN;
    return chr;
  endfunction

endpackage

@@ src/mkd_cfg.sv @@
// configuration register bank of the morse key decoder
// depends on mkd_pkg

module mkd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0] wr_data,
  output mkd_pkg::cfg_t                  cfg
);
  import mkd_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dash_hold_ticks     <= DASH_HOLD_RST;
      cfg.gap_limit_ticks     <= GAP_LIMIT_RST;
      cfg.display_start_count <= DISP_START_RST;
    end else if (wr_en) begin
      if (wr_index == CFG_DASH_HOLD)  cfg.dash_hold_ticks     <= wr_data;
      if (wr_index == CFG_GAP_LIMIT)  cfg.gap_limit_ticks     <= wr_data;
      if (wr_index == CFG_DISP_START) cfg.display_start_count <= wr_data;
    end
  end

endmodule

@@ src/mkd_core.sv @@
// per-tick key timing state machine, symbol store and pattern decode
// depends on mkd_pkg

module mkd_core #(
  parameter int unsigned MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      key,
  input  mkd_pkg::cfg_t             cfg,
  output logic [mkd_pkg::LED_W-1:0] led_next
);
  import mkd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SYMBOLS);

  phase_t                                phase, phase_next;
  logic [TICK_W-1:0]                     tick_count, tick_count_next;
  logic [SYM_W-1:0]                      last_symbol, last_symbol_next;
  logic [CNT_W-1:0]                      symbol_count, symbol_count_next;
  logic [MAX_SYMBOLS-1:0][SYM_W-1:0]     symbol_store, symbol_store_next;
  logic [LED_W-1:0]                      led_reg;
  logic [TICK_W-1:0]                     tick_mid;
  logic [TICK_W-1:0]                     tick_inc;
  sym_vec_t                              syms;
  logic [LED_W-1:0]                      decoded;

  // widen the store to the table's pattern length
  for (genvar k = 0; k < MORSE_MAX_LEN; k++) begin : g_pad
    if (k < MAX_SYMBOLS) begin : g_used
      assign syms[k] = symbol_store[k];
    end else begin : g_unused
      assign syms[k] = SYM_NONE;
    end
  end

  always_comb begin
    if (symbol_count > CNT_MAX) decoded = LED_UNKNOWN;
    else                        decoded = mkd_decode(LEN_W'(symbol_count), syms);
  end

  // phase transition, then the action of the new phase
  always_comb begin
    phase_next        = PH_IDLE;
    tick_mid          = tick_count;
    last_symbol_next  = last_symbol;
    symbol_count_next = symbol_count;
    symbol_store_next = symbol_store;
    led_next          = led_reg;

    unique case (phase)
      PH_IDLE: begin
        phase_next = PH_IDLE;
        if (key) begin
          phase_next = PH_DOT;
          tick_mid   = '0;
        end
      end
      PH_DOT: begin
        phase_next = PH_DOT;
        if (key && tick_count > cfg.dash_hold_ticks) phase_next = PH_DASH;
        else if (!key) phase_next = PH_RECORD;
        else if (tick_count != '1) tick_mid = tick_count + 1'b1;
      end
      PH_DASH: begin
        phase_next = key ? PH_DASH : PH_RECORD;
      end
      PH_RECORD: begin
        phase_next = key ? PH_DOT : PH_WAIT;
        tick_mid   = '0;
      end
      PH_WAIT: begin
        phase_next = PH_WAIT;
        if (key) begin
          phase_next = PH_DOT;
          tick_mid   = '0;
        end else if (tick_count > cfg.gap_limit_ticks) begin
          phase_next = PH_DISPLAY;
          tick_mid   = cfg.display_start_count;
        end
      end
      PH_DISPLAY: begin
        phase_next = PH_HOLD;
      end
      PH_HOLD: begin
        phase_next = (tick_count > cfg.gap_limit_ticks) ? PH_IDLE : PH_HOLD;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    tick_inc        = (tick_mid == '1) ? tick_mid : tick_mid + 1'b1;
    tick_count_next = tick_mid;

    unique case (phase_next)
      PH_IDLE: begin
        led_next          = LED_OFF;
        tick_count_next   = '0;
        symbol_store_next = '0;
        symbol_count_next = '0;
        last_symbol_next  = SYM_NONE;
      end
      PH_DOT: begin
        led_next         = LED_DOT;
        last_symbol_next = SYM_DOT;
      end
      PH_DASH: begin
        led_next         = LED_DASH;
        last_symbol_next = SYM_DASH;
        tick_count_next  = '0;
      end
      PH_RECORD: begin
        led_next = LED_OFF;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
          if (symbol_count == CNT_W'(k)) symbol_store_next[k] = last_symbol;
        end
        if (symbol_count <= CNT_MAX) symbol_count_next = symbol_count + 1'b1;
        last_symbol_next = SYM_NONE;
      end
      PH_WAIT: begin
        tick_count_next = tick_inc;
      end
      PH_DISPLAY: begin
        tick_count_next = tick_mid;
      end
      PH_HOLD: begin
        led_next        = decoded;
        tick_count_next = tick_inc;
      end
      default: begin
        tick_count_next = tick_mid;
      end
    endcase
  end

  // state update once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      last_symbol  <= SYM_NONE;
      symbol_count <= '0;
      symbol_store <= '0;
      led_reg      <= LED_OFF;
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      last_symbol  <= last_symbol_next;
      symbol_count <= symbol_count_next;
      symbol_store <= symbol_store_next;
      led_reg      <= led_next;
    end
  end

endmodule

@@ src/mkd_out_buf.sv @@
// two-beat result buffer between the decoder and the master-side stream
// depends on mkd_pkg for the data width

module mkd_out_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [mkd_pkg::LED_W-1:0] din,
  output logic                      space,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mkd_pkg::LED_W-1:0] dout
);
  import mkd_pkg::*;

  logic [1:0]       fill;
  logic [LED_W-1:0] head, tail;
  logic             pop;

  assign out_valid = fill != 2'd0;
  assign dout      = head;
  assign pop       = out_valid && out_ready;
  assign space     = fill != 2'd2 || out_ready;

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  // head is the oldest beat, tail the one behind it
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd1) head <= din;
      else begin
        head <= tail;
        tail <= din;
      end
    end else if (pop) begin
      head <= tail;
    end else if (push) begin
      if (fill == 2'd0) head <= din;
      else              tail <= din;
    end
  end

endmodule

@@ src/morse_key_decoder_unit.sv @@
// Morse key decoder: takes one key level per beat and returns one LED byte per beat
// (0x01 while a dot is held, 0x02 while a dash is held, the ASCII letter or digit
// or 0xFF for an unknown pattern after the gap timeout, 0x00 when idle). The block
// takes one beat every clock while its result buffer has space; a beat is held in
// the input register, then runs through the key timing machine and decode into the
// result buffer. Results queue in a two-beat buffer, so s_tready drops only while
// both slots are full and m_tready is low. Configuration registers (0: dash hold
// ticks, 1: gap limit ticks, 2: display start count) are written on the cfg channel,
// which is always ready; write them only while no ticks are in flight.
// depends on mkd_pkg, mkd_cfg, mkd_core, mkd_out_buf

module morse_key_decoder_unit #(
  parameter int unsigned MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave-side tick stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mkd_pkg::TDATA_W-1:0]     s_tdata,   // [0] key_pressed, [7:1] zero
  // master-side LED stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mkd_pkg::TDATA_W-1:0]     m_tdata,   // [7:0] led_out
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mkd_pkg::*;

  cfg_t             cfg;
  logic             stg_valid;
  logic             stg_key;
  logic             step;
  logic             buf_space;
  logic [LED_W-1:0] led_next;

  assign cfg_ready = 1'b1;

  mkd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input register
  assign step     = stg_valid && buf_space;
  assign s_tready = !stg_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) stg_key <= s_tdata[0];
  end

  mkd_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .key      (stg_key),
    .cfg      (cfg),
    .led_next (led_next)
  );

  mkd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .din       (led_next),
    .space     (buf_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (m_tdata)
  );

  // an accepted tick is held in the input register on the next edge
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stg_valid)
    else $error("accepted tick missing from input register");

  // a processed tick always leaves a result waiting
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed tick produced no result beat");

  // a held tick that cannot advance blocks the input side
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !buf_space |-> !s_tready)
    else $error("input accepted while result buffer full");

endmodule

@@ verif/key_scoreboard_pkg.sv @@
// led scoreboard for the morse key decoder bench: predicts the led byte of every
// tick beat and checks the led stream in order; depends on mkd_pkg

package key_scoreboard_pkg;
  import mkd_pkg::*;

  class led_scoreboard;
    // register copies
    logic [TICK_W-1:0] dash_after;
    logic [TICK_W-1:0] gap_after;
    logic [TICK_W-1:0] hold_start;

    // predicted block state
    phase_t            cur_phase;
    logic [TICK_W-1:0] tick_cnt;
    logic [SYM_W-1:0]  pend_sym;
    logic [LEN_W-1:0]  sym_len;
    logic [SYM_W-1:0]  sym_seq [MAX_SYMBOLS_DEF];
    logic [LED_W-1:0]  led_now;

    // led bytes still owed by the block, oldest first
    logic [LED_W-1:0]  led_due [$];
    // dot/dash spelling of A..Z then 1..9 and 0
    string             code_of [$];

    int errors;
    int checked;
    int decodes;
    int unknowns;
    int reg_writes;

    function new();
      string letters_txt;
      string cur;
      letters_txt = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- .--. ",
                     "--.- .-. ... - ..- ...- .-- -..- -.-- --.. .---- ..--- ...-- ....- ",
                     "..... -.... --... ---.. ----. -----"};
      cur = "";
      for (int i = 0; i < letters_txt.len(); i++) begin
        if (letters_txt.getc(i) == " ") begin
          code_of.push_back(cur);
          cur = "";
        end else begin
          cur = {cur, letters_txt.substr(i, i)};
        end
      end
      code_of.push_back(cur);
      dash_after = DASH_HOLD_RST;
      gap_after  = GAP_LIMIT_RST;
      hold_start = DISP_START_RST;
      cur_phase  = PH_IDLE;
      tick_cnt   = '0;
      led_now    = LED_OFF;
      clear_symbols();
      errors     = 0;
      checked    = 0;
      decodes    = 0;
      unknowns   = 0;
      reg_writes = 0;
    endfunction

    function void clear_symbols();
      foreach (sym_seq[k]) sym_seq[k] = SYM_NONE;
      sym_len  = '0;
      pend_sym = SYM_NONE;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DASH_HOLD:  dash_after = val;
        CFG_GAP_LIMIT:  gap_after  = val;
        CFG_DISP_START: hold_start = val;
        default: ;
      endcase
      reg_writes++;
    endfunction

    // tick counter stops at all ones
    function logic [TICK_W-1:0] bump(logic [TICK_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // spell the stored symbols and look them up in the letter list
    function logic [LED_W-1:0] lookup_glyph();
      string pat;
      pat = "";
      if (sym_len == 0 || sym_len > MAX_SYMBOLS_DEF) return LED_UNKNOWN;
      for (int k = 0; k < sym_len; k++) begin
        case (sym_seq[k])
          SYM_DOT:  pat = {pat, "."};
          SYM_DASH: pat = {pat, "-"};
          default:  pat = {pat, "?"};
        endcase
      end
      for (int k = 0; k < code_of.size(); k++) begin
        if (code_of[k] == pat) begin
          if (k < 26) return LED_W'(8'h41 + k);
          if (k == 35) return 8'h30;
          return LED_W'(8'h31 + k - 26);
        end
      end
      return LED_UNKNOWN;
    endfunction

    // one tick: pick the next phase, then run that phase's action
    function logic [LED_W-1:0] advance_keyer(logic key);
      phase_t was;
      phase_t nxt;
      was = cur_phase;
      case (cur_phase)
        PH_IDLE: begin
          nxt = PH_IDLE;
          if (key) begin
            nxt      = PH_DOT;
            tick_cnt = '0;
          end
        end
        PH_DOT: begin
          nxt = PH_DOT;
          if (key && tick_cnt > dash_after) nxt = PH_DASH;
          else if (!key) nxt = PH_RECORD;
          else tick_cnt = bump(tick_cnt);
        end
        PH_DASH: nxt = key ? PH_DASH : PH_RECORD;
        PH_RECORD: begin
          nxt      = key ? PH_DOT : PH_WAIT;
          tick_cnt = '0;
        end
        PH_WAIT: begin
          nxt = PH_WAIT;
          // a press wins over a gap timeout in the same tick
          if (key) begin
            nxt      = PH_DOT;
            tick_cnt = '0;
          end else if (tick_cnt > gap_after) begin
            nxt      = PH_DISPLAY;
            tick_cnt = hold_start;
          end
        end
        PH_DISPLAY: nxt = PH_HOLD;
        PH_HOLD:    nxt = (tick_cnt > gap_after) ? PH_IDLE : PH_HOLD;
        default:    nxt = PH_IDLE;
      endcase
      cur_phase = nxt;

      case (cur_phase)
        PH_IDLE: begin
          led_now  = LED_OFF;
          tick_cnt = '0;
          clear_symbols();
        end
        PH_DOT: begin
          led_now  = LED_DOT;
          pend_sym = SYM_DOT;
        end
        PH_DASH: begin
          led_now  = LED_DASH;
          pend_sym = SYM_DASH;
          tick_cnt = '0;
        end
        PH_RECORD: begin
          led_now = LED_OFF;
          // symbols past the store are dropped, the count stops one above it
          if (sym_len < MAX_SYMBOLS_DEF) sym_seq[sym_len] = pend_sym;
          if (sym_len <= MAX_SYMBOLS_DEF) sym_len = sym_len + 1'b1;
          pend_sym = SYM_NONE;
        end
        PH_WAIT: tick_cnt = bump(tick_cnt);
        PH_HOLD: begin
          led_now  = lookup_glyph();
          tick_cnt = bump(tick_cnt);
          if (was == PH_DISPLAY) begin
            decodes++;
            if (led_now == LED_UNKNOWN) unknowns++;
          end
        end
        default: ;
      endcase
      return led_now;
    endfunction

    function void note_tick(logic key);
      led_due.push_back(advance_keyer(key));
    endfunction

    function void check_led(logic [LED_W-1:0] got, time stamp);
      logic [LED_W-1:0] want;
      if (led_due.size() == 0) begin
        errors++;
        $display("%0t ns tb: led beat with nothing expected, expected none, got %02h",
                 stamp, got);
        return;
      end
      want = led_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t ns tb: led mismatch, expected %02h, got %02h", stamp, want, got);
      end
    endfunction

    function int pending();
      return led_due.size();
    endfunction

    function bit at_rest();
      return cur_phase == PH_IDLE;
    endfunction
  endclass

endpackage

@@ verif/tb.sv @@
// top of the morse key decoder bench: clock, reset, tick and led stream drivers,
// register writes and the run sequence; depends on mkd_pkg, key_scoreboard_pkg

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkd_pkg::*;
  import key_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_STALL  = 120;

  typedef enum {RX_FREE, RX_THREE_OF_FOUR, RX_HALF, RX_SPARSE} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register values as last written, used to shape presses and gaps
  int cfg_dash = int'(DASH_HOLD_RST);
  int cfg_gap  = int'(GAP_LIMIT_RST);
  int cfg_disp = int'(DISP_START_RST);

  int burst_left     = 0;
  int ticks_sent     = 0;
  int long_stalls    = 0;
  int cycle_count    = 0;
  bit long_stall_req = 1'b0;

  led_scoreboard sb;

  morse_key_decoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] key_pressed, [7:1] zero
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [7:0] led_out
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // beat monitor: predict on every accepted tick, check every accepted led byte
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_tick(s_tdata[0]);
      if (m_tvalid && m_tready) sb.check_led(m_tdata, $time);
    end
  end

  // led sink: stall pattern changes after random runs, long hold-off on request
  initial begin : led_sink
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_cyc;
    rx_mode = RX_FREE;
    rx_left = 0;
    rx_cyc  = 0;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        long_stalls++;
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_cyc++;
        case (rx_mode)
          RX_FREE:          m_tready <= 1'b1;
          RX_THREE_OF_FOUR: m_tready <= (rx_cyc % 4) != 3;
          RX_HALF:          m_tready <= 1'($urandom_range(0, 1));
          default:          m_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // one tick beat, sent in bursts with random gaps between them
  task automatic send_tick(input logic key);
    int idle;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 40);
      idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        s_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-1){1'b0}}, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic key_run(input logic key, input int n);
    repeat (n) send_tick(key);
  endtask

  // string of '1' and '0' key levels
  task automatic key_pattern(input string levels);
    for (int i = 0; i < levels.len(); i++) send_tick(levels.getc(i) == "1");
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // stop ticks, let every led byte out, walk the keyer to idle if gap limit != 255
  task automatic settle();
    s_tvalid <= 1'b0;
    wait_drained();
    if (cfg_gap != 255) begin
      while (!sb.at_rest()) begin
        repeat (8) send_tick(1'b0);
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  // write all three registers back to back, valid stays up between writes
  task automatic program_regs(input int dash, input int gap, input int disp);
    logic [CFG_IDX_W-1:0]  idxs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idxs[0] = CFG_DASH_HOLD;
    idxs[1] = CFG_GAP_LIMIT;
    idxs[2] = CFG_DISP_START;
    vals[0] = CFG_DATA_W'(dash);
    vals[1] = CFG_DATA_W'(gap);
    vals[2] = CFG_DATA_W'(disp);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    cfg_dash = dash;
    cfg_gap  = gap;
    cfg_disp = disp;
  endtask

  // press length around the dot/dash threshold
  function automatic int press_len(input bit as_dash);
    int top;
    if (as_dash) return cfg_dash + 3 + $urandom_range(0, 2);
    top = (cfg_dash + 2 > 10) ? 10 : cfg_dash + 2;
    return $urandom_range(1, top);
  endfunction

  function automatic string random_word();
    string w;
    int    n;
    w = "";
    n = $urandom_range(1, 7);
    repeat (n) begin
      if ($urandom_range(0, 1)) w = {w, "-"};
      else w = {w, "."};
    end
    return w;
  endfunction

  // key one pattern, gaps inside may run past the timeout, the tail is sometimes cut
  task automatic send_letter(input string code);
    int spread;
    int tail;
    spread = (cfg_gap + 2 > 12) ? 12 : cfg_gap + 2;
    tail   = cfg_gap + 4 + ((cfg_disp <= cfg_gap) ? cfg_gap - cfg_disp + 2 : 1);
    for (int i = 0; i < code.len(); i++) begin
      key_run(1'b1, press_len(code.getc(i) == "-"));
      if (i < code.len() - 1) key_run(1'b0, $urandom_range(1, spread));
    end
    if ($urandom_range(0, 4) == 0) begin
      key_run(1'b0, $urandom_range(1, tail));
      repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
    end else begin
      key_run(1'b0, tail + $urandom_range(0, 2));
    end
  endtask

  // one register setting, mostly table letters, some odd patterns and key noise
  task automatic run_phase(input int dash, input int gap, input int disp, input int n,
                           input bit squeeze);
    int  start;
    bit  stall_due;
    settle();
    program_regs(dash, gap, disp);
    start     = ticks_sent;
    stall_due = squeeze;
    while (ticks_sent - start < n) begin
      if (stall_due && ticks_sent - start > n / 3) begin
        long_stall_req = 1'b1;
        stall_due      = 1'b0;
      end
      case ($urandom_range(0, 19))
        0:       repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
        1, 2, 3: send_letter(random_word());
        default: send_letter(sb.code_of[$urandom_range(0, 35)]);
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest timing: dash after a three tick press, decode right after release
    program_regs(0, 0, 0);
    key_pattern("11100000");
    // six dots, the sixth is dropped; a press exactly at the gap timeout adds a seventh
    key_pattern("10101010101001");
    key_pattern("00000");

    run_phase(int'(DASH_HOLD_RST), int'(GAP_LIMIT_RST), int'(DISP_START_RST), 120, 1'b1);
    run_phase(0, 0, 0, 60, 1'b0);
    run_phase(2, 3, 1, 60, 1'b0);
    run_phase(6, 4, 0, 60, 1'b0);
    run_phase(1, 8, 255, 60, 1'b0);

    // all-ones limits: press and gap counters saturate, no dash and no decode
    settle();
    program_regs(255, 255, 0);
    key_run(1'b1, 262);
    key_run(1'b0, 262);
    key_run(1'b1, 2);
    key_run(1'b0, 3);

    // top of the dash and display registers: one long dash and one dot, each decoded
    settle();
    program_regs(250, 4, 250);
    key_run(1'b1, 254);
    key_run(1'b0, 12);
    key_run(1'b1, 3);
    key_run(1'b0, 12);

    run_phase(3, 5, 7, 40, 1'b0);
    settle();
    repeat (8) @(posedge clk);

    $display("tb: %0d tick beats sent, %0d led beats checked, %0d register writes",
             ticks_sent, sb.checked, sb.reg_writes);
    $display("tb: %0d patterns decoded, %0d of them unknown or too long, %0d long stalls",
             sb.decodes, sb.unknowns, long_stalls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mkd_pkg.sv
src/mkd_cfg.sv
src/mkd_core.sv
src/mkd_out_buf.sv
src/morse_key_decoder_unit.sv
verif/key_scoreboard_pkg.sv
verif/tb.sv
